// File: rtl/core/leb_pkg.sv
// ============================================================================
// leb_pkg
// Shared constants for the line edit buffer: store geometry, register
// indexes and register reset values.
// ============================================================================
`timescale 1ns / 1ps

package leb_pkg;

    // Line store geometry
    localparam int LINE_DEPTH = 64;
    localparam int ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int CNT_W      = $clog2(LINE_DEPTH + 1);

    localparam int CHAR_W     = 8;
    localparam int CFG_IDX_W  = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ERASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KILL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_END   = 2'd2;

    // Register reset values: '#', '@', LF
    localparam logic [CHAR_W-1:0] ERASE_RST = 8'd35;
    localparam logic [CHAR_W-1:0] KILL_RST  = 8'd64;
    localparam logic [CHAR_W-1:0] END_RST   = 8'd10;

    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [CHAR_W-1:0] char_t;

endpackage

// File: rtl/core/line_edit_buffer_core.sv
// ============================================================================
// line_edit_buffer_core
// Canonical-mode line editor: takes one character per transaction while
// editing, one per cycle. An end transaction of a non-empty line stalls
// input until the line store has drained, which takes longer when the
// output stalls; an empty line costs no stall. Each character of the line
// passes through the store's read register and then the output register,
// one per cycle while the output is ready.
// Async active-low reset clears count, flag, control and registers; the
// line store itself is not cleared (only written entries are ever read).
// ============================================================================
`timescale 1ns / 1ps

module line_edit_buffer_core
    import leb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    // character input channel
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [CHAR_W-1:0]    char_in,
    input  logic                 end_of_input,

    // flushed line output channel
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [CHAR_W-1:0]    char_out,
    output logic                 last,
    output logic                 line_truncated,

    // register write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CHAR_W-1:0]    cfg_data
);

    // ------------------------------------------------------------------
    // Control states
    // ------------------------------------------------------------------
    localparam logic ST_EDIT  = 1'b0;   // taking characters
    localparam logic ST_FLUSH = 1'b1;   // issuing store reads for a line

    localparam cnt_t DEPTH_CNT = CNT_W'(LINE_DEPTH);

    logic  state_reg,      state_next;
    cnt_t  fill_reg,       fill_next;      // buffered characters
    logic  ovf_reg,        ovf_next;       // a char was dropped on this line
    cnt_t  flush_cnt_reg,  flush_cnt_next; // length of line being drained
    cnt_t  rd_ptr_reg,     rd_ptr_next;    // next store entry to read
    logic  trunc_reg,      trunc_next;     // flag snapshot for the line

    // read stage: store data waits in mem_q_reg until the output takes it
    logic  pend_reg,       pend_next;
    logic  pend_last_reg,  pend_last_next;

    // output register
    logic  out_valid_reg,  out_valid_next;
    char_t out_char_reg,   out_char_next;
    logic  out_last_reg,   out_last_next;
    logic  out_trunc_reg,  out_trunc_next;

    // configuration registers
    char_t erase_reg, erase_next;
    char_t kill_reg,  kill_next;
    char_t end_reg,   end_next;

    // line store
    char_t line_mem [LINE_DEPTH];
    char_t mem_q_reg;

    logic  in_fire;
    logic  cfg_fire;
    logic  is_end;
    logic  is_erase;
    logic  is_kill;
    logic  has_room;
    logic  wr_en;
    logic  rd_en;
    logic  move;
    logic  reads_left;

    // ------------------------------------------------------------------
    // Handshakes and character decode
    // ------------------------------------------------------------------
    assign in_ready  = (state_reg == ST_EDIT);
    assign in_fire   = in_valid & in_ready;
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid & cfg_ready;

    // Priority when registers match: end, then erase, then kill.
    assign is_end    = end_of_input | (char_in == end_reg);
    assign is_erase  = ~is_end & (char_in == erase_reg);
    assign is_kill   = ~is_end & ~is_erase & (char_in == kill_reg);
    assign has_room  = (fill_reg < DEPTH_CNT);

    // Append writes the store at the current fill level.
    assign wr_en = in_fire & ~is_end & ~is_erase & ~is_kill & has_room;

    // Pending read data moves into the output register when it is free
    // or being emptied this cycle.
    assign move = pend_reg & (~out_valid_reg | out_ready);

    // A new read may overwrite mem_q_reg only once its current content
    // has moved on (or in the same cycle it moves).
    assign reads_left = (rd_ptr_reg != flush_cnt_reg);
    assign rd_en = (state_reg == ST_FLUSH) & reads_left & (~pend_reg | move);

    // ------------------------------------------------------------------
    // Next-state logic
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        ovf_next       = ovf_reg;
        flush_cnt_next = flush_cnt_reg;
        rd_ptr_next    = rd_ptr_reg;
        trunc_next     = trunc_reg;

        unique case (state_reg)
            ST_EDIT:
            begin
                if (in_fire)
                begin
                    priority if (is_end)
                    begin
                        // Line leaves the buffer; empty line only clears flag.
                        fill_next = '0;
                        ovf_next  = 1'b0;
                        if (fill_reg != '0)
                        begin
                            flush_cnt_next = fill_reg;
                            trunc_next     = ovf_reg;
                            rd_ptr_next    = '0;
                            state_next     = ST_FLUSH;
                        end
                    end
                    else if (is_erase)
                    begin
                        if (fill_reg != '0)
                            fill_next = fill_reg - cnt_t'(1);
                    end
                    else if (is_kill)
                    begin
                        fill_next = '0;     // flag stays until the line ends
                    end
                    else if (has_room)
                    begin
                        fill_next = fill_reg + cnt_t'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (rd_en)
                    rd_ptr_next = rd_ptr_reg + cnt_t'(1);
                // All reads issued and the final one handed to the output
                if (!reads_left && !pend_reg)
                    state_next = ST_EDIT;
            end
        endcase
    end

    // read stage and output register
    always_comb
    begin
        pend_next      = pend_reg;
        pend_last_next = pend_last_reg;
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        out_trunc_next = out_trunc_reg;

        // a new read refills the stage even while its old data moves on
        if (rd_en)
        begin
            pend_next      = 1'b1;
            pend_last_next = ((rd_ptr_reg + cnt_t'(1)) == flush_cnt_reg);
        end
        else if (move)
        begin
            pend_next = 1'b0;
        end

        if (move)
        begin
            out_valid_next = 1'b1;
            out_char_next  = mem_q_reg;
            out_last_next  = pend_last_reg;
            out_trunc_next = trunc_reg;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // configuration writes; an index past the list is ignored
    always_comb
    begin
        erase_next = erase_reg;
        kill_next  = kill_reg;
        end_next   = end_reg;
        if (cfg_fire)
        begin
            unique case (cfg_index)
                REG_ERASE: erase_next = cfg_data;
                REG_KILL:  kill_next  = cfg_data;
                REG_END:   end_next   = cfg_data;
                default:   ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_EDIT;
            fill_reg      <= '0;
            ovf_reg       <= 1'b0;
            flush_cnt_reg <= '0;
            rd_ptr_reg    <= '0;
            trunc_reg     <= 1'b0;
            pend_reg      <= 1'b0;
            pend_last_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            erase_reg     <= ERASE_RST;
            kill_reg      <= KILL_RST;
            end_reg       <= END_RST;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            ovf_reg       <= ovf_next;
            flush_cnt_reg <= flush_cnt_next;
            rd_ptr_reg    <= rd_ptr_next;
            trunc_reg     <= trunc_next;
            pend_reg      <= pend_next;
            pend_last_reg <= pend_last_next;
            out_valid_reg <= out_valid_next;
            erase_reg     <= erase_next;
            kill_reg      <= kill_next;
            end_reg       <= end_next;
        end
    end

    // output payload needs no reset
    always_ff @(posedge clk)
    begin
        out_char_reg  <= out_char_next;
        out_last_reg  <= out_last_next;
        out_trunc_reg <= out_trunc_next;
    end

    // ------------------------------------------------------------------
    // Line store: one write port (edit side), one registered read port
    // (flush side). Writes happen only in ST_EDIT and reads only in
    // ST_FLUSH, so the two never touch the same entry in one cycle.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (wr_en)
            line_mem[fill_reg[ADDR_W-1:0]] <= char_in;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            mem_q_reg <= line_mem[rd_ptr_reg[ADDR_W-1:0]];
    end

    assign out_valid      = out_valid_reg;
    assign char_out       = out_char_reg;
    assign last           = out_last_reg;
    assign line_truncated = out_trunc_reg;

endmodule
